// File: hdl/crr_pkg.sv
// crr_pkg: shared types, command and reply codes and the register profile
// of the charger register responder
// depends on nothing
`default_nettype none

package crr_pkg;

	// table geometry
	localparam int NUM_REGS    = 12;
	localparam int PROFILE_LEN = 12;
	localparam int LOOKUP_N    = (NUM_REGS < PROFILE_LEN) ? NUM_REGS : PROFILE_LEN;
	localparam int IDX_W       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

	localparam int WORD_W  = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [WORD_W-1:0] ERR_WORD     = 16'hAAAA;
	localparam logic [WORD_W-1:0] BATT_TYPE_ID = 16'hEDF1;
	localparam logic [WORD_W-1:0] BATT_USER    = 16'h00FF;
	localparam logic [WORD_W-1:0] VOLT_ID_A    = 16'hEDF7;
	localparam logic [WORD_W-1:0] VOLT_ID_B    = 16'hEDF6;
	localparam logic [WORD_W-1:0] VOLT_ID_C    = 16'hEDF4;
	localparam logic [WORD_W-1:0] VOLT_ID_D    = 16'hEDF2;

	// register profile: id, two-byte flag, writable flag, reset default
	localparam logic [WORD_W-1:0] PROF_ID [PROFILE_LEN] = '{
		16'h0201, 16'hEDDA, 16'hEDF0, 16'hEDF1, 16'hEDF2, 16'hEDF4,
		16'hEDF6, 16'hEDF7, 16'hEDFB, 16'hEDFD, 16'hEDEA, 16'hEDE0
	};
	localparam logic PROF_WIDE [PROFILE_LEN] = '{
		1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1
	};
	localparam logic PROF_WR [PROFILE_LEN] = '{
		1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
	};
	localparam logic [WORD_W-1:0] PROF_DFLT [PROFILE_LEN] = '{
		16'd5, 16'd0, 16'd150, 16'h00FF, 16'd0, 16'd1420,
		16'd1350, 16'd1420, 16'd200, 16'd0, 16'd12, 16'd500
	};

	// battery type register slot in the table
	localparam int   BATT_IDX     = 3;
	localparam logic BATT_PRESENT = (LOOKUP_N > BATT_IDX);
	localparam logic BATT_RESET   = BATT_PRESENT && (PROF_DFLT[BATT_IDX] == BATT_USER);

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FW_VERSION = 1'b0,
		CFG_PRODUCT_ID = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		CMD_FRAMING = 3'd0,
		CMD_PING    = 3'd1,
		CMD_APP_VER = 3'd2,
		CMD_PRODUCT = 3'd3,
		CMD_RESTART = 3'd4,
		CMD_GET     = 3'd5,
		CMD_SET     = 3'd6,
		CMD_UNSUP   = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		K_SILENT  = 3'd0,
		K_PING    = 3'd1,
		K_DONE    = 3'd2,
		K_GET     = 3'd3,
		K_SET     = 3'd4,
		K_UNKNOWN = 3'd5,
		K_ERROR   = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_UNKNOWN      = 2'd1,
		ST_NOT_WRITABLE = 2'd2,
		ST_PARAM        = 2'd3
	} status_t;

	// lookup result for one register id
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
		logic             wide;
		logic             writable;
		logic             locked;
	} lkp_t;

	function automatic logic [WORD_W-1:0] reg_default(input logic [IDX_W-1:0] idx);
		logic [WORD_W-1:0] d;
		d = '0;
		for (int i = 0; i < LOOKUP_N; i++) begin
			if (idx == IDX_W'(i)) begin
				d = PROF_DFLT[i];
			end
		end
		return d;
	endfunction

endpackage

`default_nettype wire

// File: hdl/charger_register_responder.sv
// charger_register_responder: top level, request stage, reply decision and
// output register; depends on crr_pkg, crr_lookup and crr_regfile
//
// usage
// - request channel in_valid/in_ready carries one decoded request word:
//   cmd, raw_code, payload_len, reg_id, write_value
// - reply channel out_valid/out_ready carries one reply word per request,
//   except restart, which is consumed silently
// - config channel cfg_valid/cfg_ready (always ready) writes
//   firmware_version (index 0) and product_id (index 1); write it only
//   while no request is in flight
// - at the accept edge of a request the register id is matched and the
//   value memory is read; from the request stage the reply is formed, and
//   once it can move a set writes back and the reply word is loaded into
//   the output register
// - the single value memory is read at accept and written back from the
//   request stage; a new request is taken only when the request stage is
//   empty, so reads never see a stale entry
// - the output register lets a request be accepted while the previous
//   reply still waits; when the receiver stalls, the request stage holds
//   and in_ready stays low until the reply can move
// - reset clears the valid bits so every register reads its profile
//   default, clears both config words, and drops all valids
`default_nettype none

module charger_register_responder
	import crr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// request channel
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [2:0]           cmd,
	input  wire logic [3:0]           raw_code,
	input  wire logic [3:0]           payload_len,
	input  wire logic [WORD_W-1:0]    reg_id,
	input  wire logic [WORD_W-1:0]    write_value,
	// reply channel
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [2:0]                reply_kind,
	output logic [WORD_W-1:0]         reply_id,
	output logic [1:0]                status,
	output logic [1:0]                value_bytes,
	output logic [WORD_W-1:0]         reply_value,
	// config channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]    cfg_data
);

	// config words
	logic [WORD_W-1:0] fw_version_q;
	logic [WORD_W-1:0] product_id_q;

	// request stage
	logic              s1_valid_q;
	cmd_t              cmd_s1;
	logic [3:0]        code_s1;
	logic [3:0]        len_s1;
	logic [WORD_W-1:0] id_s1;
	logic [WORD_W-1:0] wv_s1;
	lkp_t              lkp_s1;

	// battery type holds the user value, shadow of its table entry
	logic batt_user_q;

	// output register
	logic              out_valid_q;
	kind_t             kind_q;
	logic [WORD_W-1:0] rid_q;
	status_t           st_q;
	logic [1:0]        nb_q;
	logic [WORD_W-1:0] val_q;

	lkp_t              lkp_in;
	logic              in_accept;
	logic              s1_done;
	logic [WORD_W-1:0] cur_val;
	logic [WORD_W-1:0] new_val;
	logic              wr_en;
	logic              silent;
	kind_t             kind_d;
	logic [WORD_W-1:0] rid_d;
	status_t           st_d;
	logic [1:0]        nb_d;
	logic [WORD_W-1:0] val_d;
	logic [1:0]        width_bytes;
	logic [3:0]        set_len;

	assign cfg_ready = 1'b1;
	assign in_ready  = !s1_valid_q;
	assign in_accept = in_valid && in_ready;

	crr_lookup u_lookup (
		.reg_id (reg_id),
		.lkp    (lkp_in)
	);

	crr_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_accept),
		.rd_idx  (lkp_in.idx),
		.wr_en   (wr_en),
		.wr_idx  (lkp_s1.idx),
		.wr_data (new_val),
		.rd_data (cur_val)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_version_q <= '0;
			product_id_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FW_VERSION: fw_version_q <= cfg_data;
				CFG_PRODUCT_ID: product_id_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request stage capture; lookup and memory read happen at accept
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1  <= cmd_t'(cmd);
			code_s1 <= raw_code;
			len_s1  <= payload_len;
			id_s1   <= reg_id;
			wv_s1   <= write_value;
			lkp_s1  <= lkp_in;
		end
	end

	// one-byte registers keep the low byte of a set
	assign new_val     = lkp_s1.wide ? wv_s1 : {8'h00, wv_s1[7:0]};
	assign width_bytes = lkp_s1.wide ? 2'd2 : 2'd1;
	assign set_len     = lkp_s1.wide ? 4'd5 : 4'd4;

	// reply decision
	always_comb begin
		kind_d = K_ERROR;
		rid_d  = '0;
		st_d   = ST_OK;
		nb_d   = 2'd2;
		val_d  = ERR_WORD;
		silent = 1'b0;
		wr_en  = 1'b0;
		unique case (cmd_s1)
			CMD_PING: begin
				kind_d = K_PING;
				val_d  = fw_version_q;
			end
			CMD_APP_VER: begin
				kind_d = K_DONE;
				val_d  = fw_version_q;
			end
			CMD_PRODUCT: begin
				kind_d = K_DONE;
				val_d  = product_id_q;
			end
			CMD_RESTART: begin
				silent = 1'b1;
			end
			CMD_GET: begin
				if (len_s1 == 4'd3) begin
					kind_d = K_GET;
					rid_d  = id_s1;
					st_d   = lkp_s1.hit ? ST_OK : ST_UNKNOWN;
					nb_d   = lkp_s1.hit ? width_bytes : 2'd0;
					val_d  = lkp_s1.hit ? cur_val : '0;
				end
			end
			CMD_SET: begin
				if (len_s1 >= 4'd3) begin
					kind_d = K_SET;
					rid_d  = id_s1;
					if (!lkp_s1.hit) begin
						st_d = ST_UNKNOWN;
					end else if (!lkp_s1.writable) begin
						st_d = ST_NOT_WRITABLE;
					end else if (len_s1 != set_len) begin
						st_d = ST_PARAM;
					end else if (lkp_s1.locked && !batt_user_q) begin
						// charge voltages follow the battery type unless it is user defined
						st_d = ST_PARAM;
					end
					wr_en = s1_done && (st_d == ST_OK);
					nb_d  = lkp_s1.hit ? width_bytes : 2'd0;
					if (!lkp_s1.hit) begin
						val_d = '0;
					end else if (st_d == ST_OK) begin
						val_d = new_val;
					end else begin
						val_d = cur_val;
					end
				end
			end
			CMD_UNSUP: begin
				kind_d = K_UNKNOWN;
				val_d  = {12'h000, code_s1};
			end
			default: ;
		endcase
	end

	// the request stage leaves once its reply has somewhere to go
	assign s1_done = s1_valid_q && (silent || !out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			batt_user_q <= BATT_RESET;
		end else begin
			if (in_accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_done) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_done && !silent) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en && BATT_PRESENT && (lkp_s1.idx == IDX_W'(BATT_IDX))) begin
				batt_user_q <= (new_val == BATT_USER);
			end
		end
	end

	// reply payload
	always_ff @(posedge clk) begin
		if (s1_done && !silent) begin
			kind_q <= kind_d;
			rid_q  <= rid_d;
			st_q   <= st_d;
			nb_q   <= nb_d;
			val_q  <= val_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign reply_kind  = kind_q;
	assign reply_id    = rid_q;
	assign status      = st_q;
	assign value_bytes = nb_q;
	assign reply_value = val_q;

	// memory read and write-back never meet in one cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_accept && wr_en))
		else $error("value memory read and write in the same cycle");

	// a refused set leaves the table untouched
	a_refused_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (cmd_s1 == CMD_SET) && (st_d == ST_OK) && lkp_s1.hit)
		else $error("write-back without an accepted set");

	// restart produces no reply word
	a_restart_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && (cmd_s1 == CMD_RESTART)) |=>
			(out_valid_q == $past(out_valid_q && !out_ready)))
		else $error("restart produced a reply");

	// a reply with no value bytes carries a zero value
	a_empty_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (nb_q == 2'd0)) |-> (val_q == '0))
		else $error("reply value present without value bytes");

endmodule

`default_nettype wire

// File: hdl/crr_lookup.sv
// crr_lookup: matches a register id against the constant profile ids
// depends on crr_pkg
`default_nettype none

module crr_lookup
	import crr_pkg::*;
(
	input  wire logic [WORD_W-1:0] reg_id,
	output lkp_t                   lkp
);

	always_comb begin
		lkp = '0;
		// ids are distinct, so at most one compare hits
		for (int i = 0; i < LOOKUP_N; i++) begin
			if (PROF_ID[i] == reg_id) begin
				lkp.hit      = 1'b1;
				lkp.idx      = IDX_W'(i);
				lkp.wide     = PROF_WIDE[i];
				lkp.writable = PROF_WR[i];
			end
		end
		lkp.locked = (reg_id == VOLT_ID_A) || (reg_id == VOLT_ID_B) ||
			(reg_id == VOLT_ID_C) || (reg_id == VOLT_ID_D);
	end

endmodule

`default_nettype wire

// File: hdl/crr_regfile.sv
// crr_regfile: register value memory with a registered read, with per-entry valid
// bits so unwritten entries read as their profile default
// depends on crr_pkg
`default_nettype none

module crr_regfile
	import crr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [IDX_W-1:0]  rd_idx,
	input  wire logic              wr_en,
	input  wire logic [IDX_W-1:0]  wr_idx,
	input  wire logic [WORD_W-1:0] wr_data,
	output logic      [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0]   mem [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	logic [WORD_W-1:0]   rd_data_q;
	logic                rd_valid_q;
	logic [IDX_W-1:0]    rd_idx_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
			rd_idx_q  <= rd_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_idx];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : reg_default(rd_idx_q);

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for charger_register_responder, with its own
// register table predictor, random gaps on both channels and config phases
// depends on crr_pkg and charger_register_responder
`default_nettype none

module tb;
	import crr_pkg::*;

	localparam int CYCLE_LIMIT    = 1000000;
	localparam int RANDOM_ITEMS   = 1500;
	localparam int REPORT_LIMIT   = 10;
	localparam int TABLE_ENTRIES  = 12;
	localparam int DRAIN_CYCLES   = 10;

	// one reply word as the block presents it
	typedef struct packed {
		kind_t             kind;
		logic [WORD_W-1:0] id;
		status_t           st;
		logic [1:0]        nbytes;
		logic [WORD_W-1:0] value;
	} reply_t;

	// one row of the charger register profile
	typedef struct packed {
		logic [WORD_W-1:0] id;
		logic              wide;
		logic              writable;
		logic [WORD_W-1:0] dflt;
	} reg_entry_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [2:0]           cmd;
	logic [3:0]           raw_code;
	logic [3:0]           payload_len;
	logic [WORD_W-1:0]    reg_id;
	logic [WORD_W-1:0]    write_value;
	logic                 out_valid;
	logic                 out_ready;
	logic [2:0]           reply_kind;
	logic [WORD_W-1:0]    reply_id;
	logic [1:0]           status;
	logic [1:0]           value_bytes;
	logic [WORD_W-1:0]    reply_value;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	// predictor state: register values and the two config words
	logic [WORD_W-1:0] held_value [TABLE_ENTRIES];
	logic [WORD_W-1:0] fw_word;
	logic [WORD_W-1:0] product_word;

	// replies owed by the block, oldest first
	reply_t pending_replies [$];

	// traffic shaping switches
	bit sender_gaps;
	bit receiver_stalls;

	int cycle_count;
	int fail_count;
	int mismatch_count;
	int requests_sent;
	int silent_requests;
	int replies_checked;
	int cfg_writes;

	charger_register_responder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.raw_code    (raw_code),
		.payload_len (payload_len),
		.reg_id      (reg_id),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.reply_kind  (reply_kind),
		.reply_id    (reply_id),
		.status      (status),
		.value_bytes (value_bytes),
		.reply_value (reply_value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies still owed", cycle_count,
				pending_replies.size());
			$display("** charger_register_responder: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// the fixed profile: id, two-byte flag, writable flag, default
	function automatic reg_entry_t profile_entry(input int slot);
		case (slot)
			0:       return '{16'h0201, 1'b0, 1'b0, 16'd5};
			1:       return '{16'hEDDA, 1'b0, 1'b0, 16'd0};
			2:       return '{16'hEDF0, 1'b1, 1'b1, 16'd150};
			3:       return '{16'hEDF1, 1'b0, 1'b1, 16'h00FF};
			4:       return '{16'hEDF2, 1'b1, 1'b1, 16'd0};
			5:       return '{16'hEDF4, 1'b1, 1'b1, 16'd1420};
			6:       return '{16'hEDF6, 1'b1, 1'b1, 16'd1350};
			7:       return '{16'hEDF7, 1'b1, 1'b1, 16'd1420};
			8:       return '{16'hEDFB, 1'b1, 1'b1, 16'd200};
			9:       return '{16'hEDFD, 1'b0, 1'b1, 16'd0};
			10:      return '{16'hEDEA, 1'b0, 1'b1, 16'd12};
			default: return '{16'hEDE0, 1'b1, 1'b1, 16'd500};
		endcase
	endfunction

	// first table slot holding this id, only slots the table really has
	function automatic bit find_slot(input logic [WORD_W-1:0] id, output int slot);
		reg_entry_t e;
		slot = -1;
		for (int i = 0; i < NUM_REGS && i < TABLE_ENTRIES; i++) begin
			e = profile_entry(i);
			if (slot < 0 && e.id == id) begin
				slot = i;
			end
		end
		return slot >= 0;
	endfunction

	function automatic bit is_voltage_id(input logic [WORD_W-1:0] id);
		return id == VOLT_ID_A || id == VOLT_ID_B || id == VOLT_ID_C || id == VOLT_ID_D;
	endfunction

	task automatic load_register_defaults();
		reg_entry_t e;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			e = profile_entry(i);
			held_value[i] = (i < NUM_REGS) ? e.dflt : '0;
		end
		fw_word      = '0;
		product_word = '0;
	endtask

	// register reply: width and value only when the id is in the table
	function automatic reply_t register_reply(input kind_t kind,
		input logic [WORD_W-1:0] id, input status_t st, input bit hit, input int slot);
		reply_t     r;
		reg_entry_t e;
		r = '{kind, id, st, 2'd0, '0};
		if (hit) begin
			e        = profile_entry(slot);
			r.nbytes = e.wide ? 2'd2 : 2'd1;
			r.value  = held_value[slot];
		end
		return r;
	endfunction

	// works out the reply to one request and applies any set to the table;
	// returns 0 for a request that gets no reply
	function automatic bit predict_reply(input cmd_t c, input logic [3:0] code,
		input logic [3:0] len, input logic [WORD_W-1:0] id,
		input logic [WORD_W-1:0] wv, output reply_t r);
		int         slot;
		int         batt_slot;
		bit         hit;
		status_t    st;
		reg_entry_t e;
		r = '{K_ERROR, '0, ST_OK, 2'd2, ERR_WORD};
		case (c)
			CMD_PING:    r = '{K_PING, '0, ST_OK, 2'd2, fw_word};
			CMD_APP_VER: r = '{K_DONE, '0, ST_OK, 2'd2, fw_word};
			CMD_PRODUCT: r = '{K_DONE, '0, ST_OK, 2'd2, product_word};
			CMD_RESTART: return 1'b0;
			CMD_UNSUP:   r = '{K_UNKNOWN, '0, ST_OK, 2'd2, {12'd0, code}};
			CMD_GET: begin
				// any length but three is a framing problem
				if (len == 4'd3) begin
					hit = find_slot(id, slot);
					r = register_reply(K_GET, id, hit ? ST_OK : ST_UNKNOWN, hit, slot);
				end
			end
			CMD_SET: begin
				if (len >= 4'd3) begin
					hit = find_slot(id, slot);
					st  = ST_OK;
					if (!hit) begin
						st = ST_UNKNOWN;
					end else begin
						e = profile_entry(slot);
						if (!e.writable) begin
							st = ST_NOT_WRITABLE;
						end else if (int'(len) - 3 != (e.wide ? 2 : 1)) begin
							st = ST_PARAM;
						end else if (is_voltage_id(id)) begin
							// voltages only move with a user battery type
							if (!find_slot(BATT_TYPE_ID, batt_slot) ||
								held_value[batt_slot] != BATT_USER) begin
								st = ST_PARAM;
							end
						end
						if (st == ST_OK) begin
							held_value[slot] = e.wide ? wv : {8'd0, wv[7:0]};
						end
					end
					r = register_reply(K_SET, id, st, hit, slot);
				end
			end
			default: ;
		endcase
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// channel drivers
	// ------------------------------------------------------------------

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// receiver: random stalls, mostly short, a few long
	initial begin
		int hold;
		out_ready = 1'b1;
		forever begin
			@(negedge clk);
			if (receiver_stalls && $urandom_range(0, 3) == 0) begin
				hold = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
					: $urandom_range(10, 40);
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// sends one request word; valid stays high afterwards so back-to-back
	// words need no low cycle in between
	task automatic send_request(input cmd_t c, input logic [3:0] code,
		input logic [3:0] len, input logic [WORD_W-1:0] id, input logic [WORD_W-1:0] wv);
		int     gap;
		reply_t r;
		gap = sender_gaps ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= c;
		raw_code    <= code;
		payload_len <= len;
		reg_id      <= id;
		write_value <= wv;
		do begin
			@(posedge clk);
		end while (!in_ready);
		requests_sent++;
		if (predict_reply(c, code, len, id, wv, r)) begin
			pending_replies.push_back(r);
		end else begin
			silent_requests++;
		end
	endtask

	// drops valid and waits until every owed reply is back, then waits on
	// for a silent restart still in the pipe
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_replies.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// config write, only called while the block is idle
	task automatic write_config(input cfg_idx_t idx, input logic [WORD_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		if (idx == CFG_FW_VERSION) begin
			fw_word = data;
		end else begin
			product_word = data;
		end
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// reply checker
	// ------------------------------------------------------------------

	always @(posedge clk) begin : reply_check
		reply_t got;
		reply_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{kind_t'(reply_kind), reply_id, status_t'(status), value_bytes, reply_value};
			if (pending_replies.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT) begin
					$display("%0t: reply with none owed: kind %0d id %h st %0d nb %0d val %h",
						$realtime, got.kind, got.id, got.st, got.nbytes, got.value);
				end
			end else begin
				want = pending_replies.pop_front();
				replies_checked++;
				if (got.kind !== want.kind || got.id !== want.id || got.st !== want.st ||
					got.nbytes !== want.nbytes || got.value !== want.value) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("%0t: mismatch exp kind %0d id %h st %0d nb %0d val %h",
							$realtime, want.kind, want.id, want.st, want.nbytes, want.value);
						$display("%0t:          got kind %0d id %h st %0d nb %0d val %h",
							$realtime, got.kind, got.id, got.st, got.nbytes, got.value);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// profile defaults and zeroed config words straight after reset
	task automatic test_reset_defaults();
		send_request(CMD_GET, 4'h0, 4'd3, 16'h0201, 16'h0000);
		send_request(CMD_GET, 4'hF, 4'd3, 16'hEDF1, 16'hFFFF);
		send_request(CMD_GET, 4'h5, 4'd3, 16'hEDF4, 16'h1234);
		send_request(CMD_GET, 4'hA, 4'd3, 16'hEDE0, 16'h8001);
		send_request(CMD_PING, 4'h3, 4'd0, 16'h0000, 16'h0000);
		send_request(CMD_PRODUCT, 4'hC, 4'd15, 16'hFFFF, 16'hFFFF);
		wait_idle();
	endtask

	// both config words at their extremes, seen through the word replies
	task automatic test_config_words();
		write_config(CFG_FW_VERSION, 16'hFFFF);
		write_config(CFG_PRODUCT_ID, 16'h0000);
		send_request(CMD_APP_VER, 4'h1, 4'd2, 16'h0001, 16'h0002);
		send_request(CMD_PRODUCT, 4'h2, 4'd1, 16'h0003, 16'h0004);
		wait_idle();
		write_config(CFG_FW_VERSION, 16'h0000);
		write_config(CFG_PRODUCT_ID, 16'hFFFF);
		send_request(CMD_PING, 4'h4, 4'd7, 16'h7FFF, 16'h8000);
		send_request(CMD_PRODUCT, 4'h8, 4'd8, 16'h8000, 16'h7FFF);
		wait_idle();
	endtask

	// error paths, refused sets and the battery type voltage lock
	task automatic test_special_cases();
		send_request(CMD_FRAMING, 4'h9, 4'd3, 16'hEDF0, 16'h0055);
		send_request(CMD_UNSUP, 4'hF, 4'd4, 16'hEDF0, 16'h0055);
		// restart answers nothing
		send_request(CMD_RESTART, 4'h6, 4'd3, 16'hEDF0, 16'h0055);
		send_request(CMD_GET, 4'h5, 4'd15, 16'hEDF0, 16'h0000);
		send_request(CMD_SET, 4'h6, 4'd2, 16'hEDF0, 16'h0077);
		send_request(CMD_SET, 4'h6, 4'd5, 16'hFFFF, 16'h0077);
		send_request(CMD_SET, 4'h6, 4'd4, 16'h0201, 16'h0077);
		// width mismatch on a two-byte register
		send_request(CMD_SET, 4'h6, 4'd4, 16'hEDF0, 16'h0077);
		// one-byte register keeps only the low byte: battery type leaves user
		send_request(CMD_SET, 4'h6, 4'd4, 16'hEDF1, 16'h1200);
		send_request(CMD_SET, 4'h6, 4'd5, 16'hEDF7, 16'h0600);
		send_request(CMD_SET, 4'h6, 4'd4, 16'hEDF1, 16'hABFF);
		send_request(CMD_SET, 4'h6, 4'd5, 16'hEDF2, 16'hFFFF);
		send_request(CMD_GET, 4'h5, 4'd3, 16'hEDF2, 16'h0000);
		wait_idle();
	endtask

	// one random request, mostly well-formed register traffic
	task automatic send_random_request();
		int               r;
		int               slot;
		reg_entry_t       e;
		logic [3:0]       len;
		logic [WORD_W-1:0] id;
		logic [WORD_W-1:0] wv;
		r    = $urandom_range(0, 99);
		slot = $urandom_range(0, TABLE_ENTRIES - 1);
		e    = profile_entry(slot);
		len  = 4'($urandom_range(0, 15));
		id   = 16'($urandom());
		wv   = 16'($urandom());
		case ($urandom_range(0, 9))
			0:       wv = 16'h0000;
			1:       wv = 16'hFFFF;
			default: ;
		endcase
		if (r < 35) begin
			if ($urandom_range(0, 9) != 0) len = 4'd3;
			send_request(CMD_GET, 4'($urandom_range(0, 15)), len, e.id, wv);
		end else if (r < 70) begin
			if ($urandom_range(0, 9) != 0) len = e.wide ? 4'd5 : 4'd4;
			// battery type often goes back to user so the voltages unlock
			if (e.id == BATT_TYPE_ID && $urandom_range(0, 1) == 0) wv[7:0] = 8'hFF;
			send_request(CMD_SET, 4'($urandom_range(0, 15)), len, e.id, wv);
		end else if (r < 78) begin
			send_request($urandom_range(0, 1) ? CMD_GET : CMD_SET,
				4'($urandom_range(0, 15)), len, id, wv);
		end else if (r < 86) begin
			send_request(cmd_t'($urandom_range(1, 3)), 4'($urandom_range(0, 15)), len, id, wv);
		end else if (r < 90) begin
			send_request(CMD_RESTART, 4'($urandom_range(0, 15)), len, id, wv);
		end else if (r < 95) begin
			send_request(CMD_UNSUP, 4'($urandom_range(0, 15)), len, id, wv);
		end else begin
			send_request(CMD_FRAMING, 4'($urandom_range(0, 15)), len, id, wv);
		end
	endtask

	// three phases: idling on both sides, none at all, then idling again
	// with fresh config words before each
	task automatic test_random_traffic();
		for (int phase = 0; phase < 3; phase++) begin
			sender_gaps     = (phase != 1);
			receiver_stalls = (phase != 1);
			write_config(CFG_FW_VERSION, 16'($urandom()));
			write_config(CFG_PRODUCT_ID, 16'($urandom()));
			for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
				send_random_request();
			end
			wait_idle();
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin
		int leftover;
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		cmd             = '0;
		raw_code        = '0;
		payload_len     = '0;
		reg_id          = '0;
		write_value     = '0;
		cfg_valid       = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
		load_register_defaults();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_config_words();
		test_special_cases();
		test_random_traffic();

		// drain: nothing owed, then a quiet wait for stray replies
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		leftover   = pending_replies.size();
		fail_count += leftover;

		$display("covered %0d requests (%0d silent restarts), %0d replies checked",
			requests_sent, silent_requests, replies_checked);
		$display("%0d config writes, %0d mismatches, %0d failures in total",
			cfg_writes, mismatch_count, fail_count);
		if (fail_count == 0) begin
			$display("** charger_register_responder: PASSED **");
		end else begin
			$display("** charger_register_responder: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire
